FILE: hw/rtl/jddm_pkg.sv
// package for the joystick differential drive mixer
// holds the shared item types, the queue depth default and the boundary angle table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jddm_pkg;

    localparam int AXIS_W = 9;
    localparam int DUTY_W = 8;
    localparam int BYTE_W = 8;
    localparam int RAW_MAX = 1023;
    localparam logic [BYTE_W-1:0] DEAD_ZONE_RESET = 8'd60;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // joystick position after a completed byte pair
    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
    } axis_pair_t;

    // one result beat
    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              left_forward;
        logic              right_forward;
    } drive_t;

    // boundary angles, unit vectors in q2.16
    localparam int A_0     = 0;
    localparam int A_070   = 1;
    localparam int A_079   = 2;
    localparam int A_087   = 3;
    localparam int A_157   = 4;
    localparam int A_223   = 5;
    localparam int A_236   = 6;
    localparam int A_247   = 7;
    localparam int A_314   = 8;
    localparam int A_M314  = 9;
    localparam int A_M240  = 10;
    localparam int A_M236  = 11;
    localparam int A_M230  = 12;
    localparam int A_M157  = 13;
    localparam int A_M090  = 14;
    localparam int A_M079  = 15;
    localparam int A_M060  = 16;
    localparam int ANGLE_COUNT = 17;

    localparam int COEF_W  = 18;
    localparam int CROSS_W = COEF_W + AXIS_W + 1;

    localparam logic signed [COEF_W-1:0] ANGLE_C [ANGLE_COUNT] = '{
        18'sd65536,  18'sd50125,  18'sd46127,  18'sd42259,  18'sd52,
        -18'sd40140, -18'sd46517, -18'sd51304, -18'sd65536, -18'sd65536,
        -18'sd48326, -18'sd46517, -18'sd43665, 18'sd52,     18'sd40738,
        18'sd46127,  18'sd54089
    };

    localparam logic signed [COEF_W-1:0] ANGLE_S [ANGLE_COUNT] = '{
        18'sd0,      18'sd42219,  18'sd46554,  18'sd50091,  18'sd65536,
        18'sd51805,  18'sd46164,  18'sd40779,  18'sd104,    -18'sd104,
        -18'sd44267, -18'sd46164, -18'sd48871, -18'sd65536, -18'sd51336,
        -18'sd46554, -18'sd37004
    };

endpackage

`default_nettype wire

FILE: hw/rtl/joystick_differential_drive_mixer.sv
// top level of the joystick differential drive mixer
// depends on jddm_pkg, jddm_fifo, jddm_front and jddm_back
`timescale 1ns / 1ps
`default_nettype none

// usage:
// - byte channel: rx_byte is taken on a clock edge with push high and full low
// - bytes come in pairs; the first of a pair gives no result, the second gives
//   exactly one result beat with both duties and both direction bits
// - result channel: while empty is low the oldest result sits on left_duty,
//   right_duty, left_forward and right_forward; pop high takes it
// - config channel: cfg_data is the dead zone, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, write only while idle
// rate and data path:
// - one byte per cycle sustained while full is low; a result goes through the
//   pair queue, then the back stage classifier, into the result queue
// - the byte side sets the rate; the back stage classifies one pair a cycle
//   while the result queue is not full, with seventeen parallel constant
//   cross products, twice what it needs
// reset: axes, held outputs and pairing clear, dead zone returns to 60
// stall: with pop low the result queue fills, then the pair queue, then
//   full rises; nothing is dropped and buffered beats keep their order
module joystick_differential_drive_mixer #(
    parameter int QUEUE_DEPTH = jddm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input, queue style
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    // dead zone write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    // drive results, queue style
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      left_duty,
    output logic [7:0]      right_duty,
    output logic            left_forward,
    output logic            right_forward
);

    import jddm_pkg::*;

    logic       in_take;
    logic       cfg_take;

    // front to pair queue
    logic       pair_push;
    axis_pair_t pair_in;
    logic       pair_full;

    // pair queue to back stage
    axis_pair_t pair_out;
    logic       pair_empty;
    logic       pair_pop;

    // back stage to result queue
    logic       drive_push;
    drive_t     drive_in;
    logic       drive_full;
    drive_t     drive_out;

    // a full pair queue stops the byte side even on a first byte
    assign full      = pair_full;
    assign in_take   = push && !pair_full;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    jddm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .rx_byte   (rx_byte),
        .pair_push (pair_push),
        .pair_data (pair_in)
    );

    jddm_fifo #(
        .WIDTH ($bits(axis_pair_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_pair_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pair_push),
        .push_data (pair_in),
        .full      (pair_full),
        .pop       (pair_pop),
        .pop_data  (pair_out),
        .empty     (pair_empty)
    );

    jddm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_take   (cfg_take),
        .cfg_data   (cfg_data),
        .pair_valid (!pair_empty),
        .pair_data  (pair_out),
        .pair_pop   (pair_pop),
        .drive_full (drive_full),
        .drive_push (drive_push),
        .drive_data (drive_in)
    );

    jddm_fifo #(
        .WIDTH ($bits(drive_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_drive_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (drive_push),
        .push_data (drive_in),
        .full      (drive_full),
        .pop       (pop),
        .pop_data  (drive_out),
        .empty     (empty)
    );

    assign left_duty     = drive_out.left_duty;
    assign right_duty    = drive_out.right_duty;
    assign left_forward  = drive_out.left_forward;
    assign right_forward = drive_out.right_forward;

endmodule

`default_nettype wire

FILE: hw/rtl/jddm_fifo.sv
// small register queue used between the mixer stages and at the result side
// depends on nothing but its parameters; depth of two or more
`timescale 1ns / 1ps
`default_nettype none

module jddm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jddm_front.sv
// front stage: pairs received bytes, maps the value and updates the axis it names
// depends on jddm_pkg
`timescale 1ns / 1ps
`default_nettype none

module jddm_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_take,
    input  wire logic [7:0]             rx_byte,
    output logic                        pair_push,
    output jddm_pkg::axis_pair_t        pair_data
);

    import jddm_pkg::*;

    logic                     awaiting_second_reg;
    logic [BYTE_W-1:0]        first_byte_reg;
    logic signed [AXIS_W-1:0] x_axis_reg, x_axis_next;
    logic signed [AXIS_W-1:0] y_axis_reg, y_axis_next;

    logic [11:0]              raw_full;
    logic [9:0]               raw_sat;
    logic signed [11:0]       centered;
    logic [10:0]              centered_mag;
    logic [AXIS_W-1:0]        quarter;
    logic signed [AXIS_W-1:0] mapped;

    always_comb
    begin
        raw_full = {rx_byte, 4'b0000} | {4'b0000, first_byte_reg};
        raw_sat  = (raw_full > 12'(RAW_MAX)) ? 10'(RAW_MAX) : raw_full[9:0];
        centered = $signed({1'b0, raw_sat, 1'b0}) - 12'sd1023;
        // truncate toward zero: shift the magnitude, then restore the sign
        centered_mag = centered[11] ? 11'(-centered) : centered[10:0];
        quarter      = AXIS_W'(centered_mag >> 2);
        mapped       = centered[11] ? $signed(-quarter) : $signed(quarter);

        x_axis_next = x_axis_reg;
        y_axis_next = y_axis_reg;
        if (first_byte_reg[0])
        begin
            x_axis_next = mapped;
        end
        else
        begin
            y_axis_next = mapped;
        end
    end

    assign pair_push   = in_take && awaiting_second_reg;
    assign pair_data.x = x_axis_next;
    assign pair_data.y = y_axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_second_reg <= 1'b0;
            first_byte_reg      <= '0;
            x_axis_reg          <= '0;
            y_axis_reg          <= '0;
        end
        else if (in_take)
        begin
            awaiting_second_reg <= !awaiting_second_reg;
            if (!awaiting_second_reg)
            begin
                first_byte_reg <= rx_byte;
            end
            else
            begin
                x_axis_reg <= x_axis_next;
                y_axis_reg <= y_axis_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jddm_back.sv
// back stage: sector classification by cross products and the held drive outputs
// depends on jddm_pkg; also holds the dead zone register
`timescale 1ns / 1ps
`default_nettype none

module jddm_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_take,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   pair_valid,
    input  wire jddm_pkg::axis_pair_t   pair_data,
    output logic                        pair_pop,
    input  wire logic                   drive_full,
    output logic                        drive_push,
    output jddm_pkg::drive_t            drive_data
);

    import jddm_pkg::*;

    logic [BYTE_W-1:0]         dead_zone_reg;
    drive_t                    held_reg, held_next;

    logic signed [CROSS_W-1:0] cross_v [ANGLE_COUNT];
    logic [ANGLE_COUNT-1:0]    pos;
    logic [ANGLE_COUNT-1:0]    neg;
    logic [ANGLE_COUNT-1:0]    zero;
    logic signed [AXIS_W-1:0]  x;
    logic signed [AXIS_W-1:0]  y;
    logic signed [AXIS_W-1:0]  neg_x;
    logic signed [AXIS_W-1:0]  neg_y;
    logic [DUTY_W-1:0]         ax;
    logic [DUTY_W-1:0]         ay;
    logic [DUTY_W-1:0]         rm;
    logic                      take;

    assign take       = pair_valid && !drive_full;
    assign pair_pop   = take;
    assign drive_push = take;
    assign drive_data = held_next;

    assign x = pair_data.x;
    assign y = pair_data.y;

    always_comb
    begin
        for (int i = 0; i < ANGLE_COUNT; i++)
        begin
            // operands widened before the multiply so no product wraps
            cross_v[i] = CROSS_W'(ANGLE_C[i]) * CROSS_W'(y)
                       - CROSS_W'(ANGLE_S[i]) * CROSS_W'(x);
            zero[i]    = (cross_v[i] == '0);
            neg[i]     = cross_v[i][CROSS_W-1];
            pos[i]     = !neg[i] && !zero[i];
        end
    end

    always_comb
    begin
        neg_x = -x;
        neg_y = -y;
        ax    = x[AXIS_W-1] ? neg_x[DUTY_W-1:0] : x[DUTY_W-1:0];
        ay    = y[AXIS_W-1] ? neg_y[DUTY_W-1:0] : y[DUTY_W-1:0];
        rm    = (ax > ay) ? ax - ay : ay - ax;

        held_next = held_reg;
        if (ax < dead_zone_reg && ay < dead_zone_reg)
        begin
            held_next = '0;
        end
        // diagonal cut-outs clear one direction bit only
        else if (pos[A_070] && neg[A_087])
        begin
            held_next = '{ax, '0, held_reg.left_forward, 1'b0};
        end
        else if (pos[A_223] && neg[A_247])
        begin
            held_next = '{'0, ax, 1'b0, held_reg.right_forward};
        end
        else if (pos[A_M240] && neg[A_M230])
        begin
            held_next = '{ax, '0, 1'b0, held_reg.right_forward};
        end
        else if (pos[A_M090] && neg[A_M060])
        begin
            held_next = '{'0, ax, held_reg.left_forward, 1'b0};
        end
        else if (pos[A_0] && neg[A_079])
        begin
            held_next = '{ax, rm, 1'b1, 1'b0};
        end
        else if (pos[A_079] && neg[A_157])
        begin
            held_next = '{ay, rm, 1'b1, 1'b1};
        end
        else if (pos[A_157] && neg[A_236])
        begin
            held_next = '{rm, ay, 1'b1, 1'b1};
        end
        else if (pos[A_236] && neg[A_314])
        begin
            // a point exactly on 2.47 stops the left motor
            held_next = '{zero[A_247] ? '0 : rm, ax, 1'b0, 1'b1};
        end
        else if (pos[A_M314] && !pos[A_M236])
        begin
            held_next = '{ax, rm, 1'b0, 1'b1};
        end
        else if (pos[A_M236] && neg[A_M157])
        begin
            held_next = '{ay, rm, 1'b0, 1'b0};
        end
        else if (pos[A_M157] && neg[A_M079])
        begin
            held_next = '{rm, ay, 1'b0, 1'b0};
        end
        else if (pos[A_M079] && neg[A_0])
        begin
            held_next = '{rm, ax, 1'b1, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RESET;
            held_reg      <= '0;
        end
        else
        begin
            if (cfg_take)
            begin
                dead_zone_reg <= cfg_data;
            end
            if (take)
            begin
                held_reg <= held_next;
            end
        end
    end

endmodule

`default_nettype wire
